/* src/mp3d_pkg.sv */
// Package for the 3D maximal point block: payload structs, controller states
// and the command and status groups between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mp3d_pkg;

    localparam int MP3D_MAX_POINTS = 64;
    localparam int MP3D_COORD_BITS = 16;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic               last_point;
    } t_point_in;

    typedef struct packed {
        logic signed [15:0] max_x;
        logic signed [15:0] max_y;
        logic signed [15:0] max_z;
        logic               last_result;
        logic               overflow;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_SCAN_DEC,
        ST_CHECK,
        ST_CHECK_END,
        ST_CHECK_DEC
    } t_state;

    typedef struct packed {
        logic load;         // store or drop the incoming point
        logic begin_set;    // clear search state for a new set
        logic rd;           // read the store at the walk index and advance it
        logic rd_chk;       // the read belongs to the cover check, not the search
        logic start_check;  // rewind the walk and clear the cover flag
        logic accept_best;  // close a round: emit, move the threshold on
        logic finish;       // emit the held point as the final one, empty the store
    } t_ctl_cmd;

    typedef struct packed {
        logic idx_last;     // the walk index points at the last stored entry
        logic found;        // the search found a point below the threshold
    } t_dp_stat;

endpackage
`default_nettype wire

/* src/mp3d_ctrl.sv */
// Controller of the 3D maximal point block: state machine issuing commands to
// the datapath. Depends on mp3d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mp3d_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_last_point,
    input  wire mp3d_pkg::t_dp_stat i_stat,
    output mp3d_pkg::t_ctl_cmd     o_cmd,
    output logic                   o_busy
);
    import mp3d_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_last_point) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.idx_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END:  n_state = ST_SCAN_DEC;
            ST_SCAN_DEC: begin
                n_state = i_stat.found ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK: begin
                if (i_stat.idx_last) begin
                    n_state = ST_CHECK_END;
                end
            end
            ST_CHECK_END: n_state = ST_CHECK_DEC;
            ST_CHECK_DEC: n_state = ST_SCAN;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy          = 1'b0;
                o_cmd.load      = i_start;
                o_cmd.begin_set = i_start && i_last_point;
            end
            ST_SCAN:  o_cmd.rd = 1'b1;
            ST_SCAN_DEC: begin
                o_cmd.start_check = i_stat.found;
                o_cmd.finish      = !i_stat.found;
            end
            ST_CHECK: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_chk = 1'b1;
            end
            ST_CHECK_DEC: o_cmd.accept_best = 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* src/mp3d_dp.sv */
// Datapath of the 3D maximal point block: point store, walk index, search and
// cover-check registers and the result register. Depends on mp3d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mp3d_dp #(
    parameter int MAX_POINTS = mp3d_pkg::MP3D_MAX_POINTS,
    parameter int COORD_BITS = mp3d_pkg::MP3D_COORD_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mp3d_pkg::t_point_in i_point,
    input  wire mp3d_pkg::t_ctl_cmd  i_cmd,
    output mp3d_pkg::t_dp_stat      o_stat,
    output mp3d_pkg::t_result       o_result,
    output logic                    o_result_valid
);
    import mp3d_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int PW   = 3 * CW;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);

    function automatic logic [CW-1:0] to_coord(input logic [15:0] f);
        logic [CW+15:0] e;
        e = {{CW{1'b0}}, f};
        return e[CW-1:0];
    endfunction

    function automatic logic [15:0] to_field(input logic [CW-1:0] c);
        logic [CW+15:0] e;
        e = {16'b0, c};
        return e[15:0];
    endfunction

    // Strict descending-lexicographic order: true when a comes after b.
    function automatic logic lex_lt(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic signed [CW-1:0] ax, ay, az, bx, by, bz;
        ax = a[PW-1:2*CW]; ay = a[2*CW-1:CW]; az = a[CW-1:0];
        bx = b[PW-1:2*CW]; by = b[2*CW-1:CW]; bz = b[CW-1:0];
        return (ax < bx) || ((ax == bx) && ((ay < by) || ((ay == by) && (az < bz))));
    endfunction

    function automatic logic covers(input logic [PW-1:0] q, input logic [PW-1:0] p);
        logic signed [CW-1:0] qx, qy, qz, px, py, pz;
        qx = q[PW-1:2*CW]; qy = q[2*CW-1:CW]; qz = q[CW-1:0];
        px = p[PW-1:2*CW]; py = p[2*CW-1:CW]; pz = p[CW-1:0];
        return (qx >= px) && (qy >= py) && (qz >= pz);
    endfunction

    logic [PW-1:0]   mem [MAX_POINTS];
    logic [AW-1:0]   r_idx;
    logic [CNTW-1:0] r_count;
    logic            r_dropped;
    logic            r_rd_vld;
    logic            r_rd_chk;
    logic [PW-1:0]   r_rd_data;
    logic [PW-1:0]   r_best;
    logic            r_found;
    logic [PW-1:0]   r_thr;
    logic            r_has_thr;
    logic            r_dom;
    logic [PW-1:0]   r_pend;
    logic            r_pend_vld;
    t_result         r_out;
    logic            r_strobe;

    logic            room;
    logic [CNTW-1:0] count_m1;
    logic            take_best;
    logic            hit_cover;
    logic            emit_round;
    logic            emit_any;
    logic [PW-1:0]   emit_pt;

    assign room      = r_count < CNTW'(MAX_POINTS);
    assign count_m1  = r_count - 1'b1;
    assign take_best = r_rd_vld && !r_rd_chk && (!r_has_thr || lex_lt(r_rd_data, r_thr))
                       && (!r_found || lex_lt(r_best, r_rd_data));
    assign hit_cover = r_rd_vld && r_rd_chk && (r_rd_data != r_best)
                       && covers(r_rd_data, r_best);
    assign emit_round = i_cmd.accept_best && !r_dom && r_pend_vld;
    assign emit_any   = emit_round || i_cmd.finish;
    assign emit_pt    = r_pend;

    assign o_stat.idx_last = (CNTW'(r_idx) == count_m1);
    assign o_stat.found    = r_found;
    assign o_result        = r_out;
    assign o_result_valid  = r_strobe;

    // Store: one write port for loading, one registered read port for the walks.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            mem[r_count[AW-1:0]] <= {to_coord(i_point.point_x), to_coord(i_point.point_y),
                                     to_coord(i_point.point_z)};
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_count    <= '0;
            r_dropped  <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rd_chk   <= 1'b0;
            r_found    <= 1'b0;
            r_has_thr  <= 1'b0;
            r_dom      <= 1'b0;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            r_rd_chk <= i_cmd.rd_chk;
            r_strobe <= emit_any;
            if (i_cmd.load) begin
                if (room) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.begin_set) begin
                r_idx      <= '0;
                r_found    <= 1'b0;
                r_has_thr  <= 1'b0;
                r_pend_vld <= 1'b0;
            end else if (i_cmd.rd) begin
                r_idx <= r_idx + 1'b1;
            end else if (i_cmd.start_check) begin
                r_idx <= '0;
                r_dom <= 1'b0;
            end else if (i_cmd.accept_best) begin
                r_idx     <= '0;
                r_found   <= 1'b0;
                r_has_thr <= 1'b1;
                if (!r_dom) begin
                    r_pend_vld <= 1'b1;
                end
            end else if (i_cmd.finish) begin
                r_count    <= '0;
                r_dropped  <= 1'b0;
                r_pend_vld <= 1'b0;
            end
            if (take_best) begin
                r_found <= 1'b1;
            end
            if (hit_cover) begin
                r_dom <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_best) begin
            r_best <= r_rd_data;
        end
        if (i_cmd.accept_best) begin
            r_thr <= r_best;
            if (!r_dom) begin
                r_pend <= r_best;
            end
        end
        if (emit_any) begin
            r_out.max_x       <= to_field(emit_pt[PW-1:2*CW]);
            r_out.max_y       <= to_field(emit_pt[2*CW-1:CW]);
            r_out.max_z       <= to_field(emit_pt[CW-1:0]);
            r_out.last_result <= i_cmd.finish;
            r_out.overflow    <= r_dropped;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_POINTS))
        else $error("point count beyond store capacity");
    a_finish_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_count == '0) && !r_dropped)
        else $error("store not emptied after the set");
    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.last_result) |=> !r_strobe)
        else $error("result after the final result");
    a_finish_has_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> r_pend_vld)
        else $error("set closed without a maximal point held");

endmodule
`default_nettype wire

/* src/maximal_points_3d.sv */
// Top level of the 3D maximal point block: controller plus datapath.
// Depends on mp3d_pkg, mp3d_ctrl and mp3d_dp.
//
//   Channel  | Ports                         | Transfer when
//   ---------+-------------------------------+------------------------------
//   points   | i_start, o_busy, i_point      | i_start high and o_busy low
//   results  | o_result_valid, o_result      | o_result_valid high (one cycle)
//
// Points are loaded one per cycle while o_busy is low; it stays low between sets
// so a new point can be transferred on every clock edge.
// The point carrying last_point starts the computation. Each round walks the
// stored points twice through the single read port of the store: once to find
// the next lower distinct point in descending (x, y, z) order and once to check
// whether any other point covers it. o_busy is high while the set is being
// computed, after the final point.
// A result is held until the next maximal point is kept or the set ends; the
// final one is marked with last_result. The receiver cannot stall the output.
// Reset is synchronous and active low; it empties the store at once and needs
// no clearing pass, since only entries below the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module maximal_points_3d #(
    parameter int MAX_POINTS = mp3d_pkg::MP3D_MAX_POINTS,
    parameter int COORD_BITS = mp3d_pkg::MP3D_COORD_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire mp3d_pkg::t_point_in i_point,
    output logic                    o_busy,
    output logic                    o_result_valid,
    output mp3d_pkg::t_result       o_result
);
    import mp3d_pkg::*;

    // Commands flow from the controller to the datapath, status flows back.
    t_ctl_cmd cmd;
    t_dp_stat stat;

    mp3d_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_last_point (i_point.last_point),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_busy       (o_busy)
    );

    mp3d_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_point        (i_point),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule
`default_nettype wire

/* test/testbench.sv */
// Testbench for maximal_points_3d: drives point sets through the points
// channel and checks every maximal point against a behavioural predictor.
// Depends on mp3d_pkg and the maximal_points_3d RTL.
`timescale 1ns / 1ps
module testbench;
    import mp3d_pkg::*;

    localparam int CAP = MP3D_MAX_POINTS;
    localparam int WATCHDOG_LIMIT = 40000;

    logic      clk;
    logic      rst_n;
    logic      start;
    t_point_in point;
    logic      busy;
    logic      res_valid;
    t_result   res;

    maximal_points_3d u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_point        (point),
        .o_busy         (busy),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    // The clock runs for the whole simulation.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Predictor state: the points of the set being loaded and the sticky
    // flag that records a dropped point.
    logic signed [15:0] set_x [CAP];
    logic signed [15:0] set_y [CAP];
    logic signed [15:0] set_z [CAP];
    int                 set_fill;
    logic               set_dropped;
    t_result            skyline_q [$];
    int                 fail_count;
    int                 idle_cycles = 0;

    // True when point a comes before point b in descending (x, y, z) order.
    function automatic logic ahead(input int a, input int b);
        if (set_x[a] != set_x[b]) return set_x[a] > set_x[b];
        if (set_y[a] != set_y[b]) return set_y[a] > set_y[b];
        return set_z[a] > set_z[b];
    endfunction

    function automatic logic same_point(input int a, input int b);
        return set_x[a] == set_x[b] && set_y[a] == set_y[b] && set_z[a] == set_z[b];
    endfunction

    // Store or drop one point; on the final one queue the skyline in
    // descending order and empty the set.
    task automatic predict_point(input t_point_in p);
        int      order [$];
        int      pos;
        logic    keep;
        t_result r;
        if (set_fill < CAP) begin
            set_x[set_fill] = p.point_x;
            set_y[set_fill] = p.point_y;
            set_z[set_fill] = p.point_z;
            set_fill++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!p.last_point) return;
        for (int i = 0; i < set_fill; i++) begin
            pos = 0;
            while (pos < order.size() && !ahead(i, order[pos])) pos++;
            order.insert(pos, i);
        end
        pos = -1;
        for (int i = 0; i < order.size(); i++) begin
            if (i > 0 && same_point(order[i], order[i-1])) continue;
            keep = 1'b1;
            for (int j = 0; j < set_fill; j++) begin
                if (!same_point(j, order[i]) && set_x[j] >= set_x[order[i]]
                        && set_y[j] >= set_y[order[i]] && set_z[j] >= set_z[order[i]])
                    keep = 1'b0;
            end
            if (keep) begin
                r.max_x = set_x[order[i]];
                r.max_y = set_y[order[i]];
                r.max_z = set_z[order[i]];
                r.last_result = 1'b0;
                r.overflow = set_dropped;
                skyline_q.insert(skyline_q.size(), r);
                pos = skyline_q.size() - 1;
            end
        end
        if (pos >= 0) skyline_q[pos].last_result = 1'b1;
        set_fill = 0;
        set_dropped = 1'b0;
    endtask

    // Results are sampled at the edge that ends their one-cycle window.
    always @(posedge clk) begin
        if (rst_n && res_valid) begin
            if (skyline_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, res);
                fail_count++;
            end else begin
                if (res !== skyline_q[0]) begin
                    $display("%0t: result mismatch, expected %h, actual %h",
                             $time, skyline_q[0], res);
                    fail_count++;
                end
                void'(skyline_q.pop_front());
            end
        end
    end

    // The watchdog counts cycles in which no transfer happens in either direction.
    always @(posedge clk) begin
        if ((start && !busy) || res_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Directed table: a marked row carries a typed-in expectation that the
    // predictor must agree with.
    typedef struct {
        t_point_in pt;
        logic      typed;
        t_result   want;
    } t_row;

    t_row rows [$];
    int   gap_left;
    int   items_sent;
    logic quiet_end;

    function automatic t_point_in mk(input int x, input int y, input int z, input logic l);
        t_point_in p;
        p.point_x = 16'(x);
        p.point_y = 16'(y);
        p.point_z = 16'(z);
        p.last_point = l;
        return p;
    endfunction

    function automatic t_result rs(input int x, input int y, input int z,
                                   input logic l, input logic o);
        t_result r;
        r.max_x = 16'(x);
        r.max_y = 16'(y);
        r.max_z = 16'(z);
        r.last_result = l;
        r.overflow = o;
        return r;
    endfunction

    task automatic add_row(input t_point_in p, input logic typed, input t_result w);
        t_row row;
        row.pt = p;
        row.typed = typed;
        row.want = w;
        rows.insert(rows.size(), row);
    endtask

    // Transfer one point: idle for any pending burst, then hold start until busy
    // is sampled low. Called just after the clock rises.
    task automatic send_point(input t_point_in p);
        if (gap_left > 0) begin
            start <= 1'b0;
            while (gap_left > 0) begin
                gap_left--;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        point <= p;
        forever begin
            @(posedge clk);
            if (!busy) break;
        end
        predict_point(p);
        items_sent++;
        if (!quiet_end && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 7);
    endtask

    function automatic int rcoord(input int mode);
        case (mode)
            0: return $urandom_range(0, 7) - 4;
            1: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 2)
                                           : -32768 + $urandom_range(0, 2);
            default: return $urandom & 16'hffff;
        endcase
    endfunction

    initial begin
        int n;
        int mode;
        fail_count = 0;
        set_fill = 0;
        set_dropped = 1'b0;
        items_sent = 0;
        gap_left = 0;
        quiet_end = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        point = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Single point, extreme coordinates.
        add_row(mk(32767, -32768, 32767, 1), 1'b1, rs(32767, -32768, 32767, 1, 0));
        add_row(mk(-32768, -32768, -32768, 1), 1'b1, rs(-32768, -32768, -32768, 1, 0));
        // Duplicates are emitted once.
        add_row(mk(5, 5, 5, 0), 1'b0, '0);
        add_row(mk(5, 5, 5, 1), 1'b1, rs(5, 5, 5, 1, 0));
        // One point covers another.
        add_row(mk(1, 1, 1, 0), 1'b0, '0);
        add_row(mk(2, 2, 2, 1), 1'b1, rs(2, 2, 2, 1, 0));
        // Incomparable points and one covered point, sign boundary.
        add_row(mk(-1, 0, 3, 0), 1'b0, '0);
        add_row(mk(0, -1, 3, 0), 1'b0, '0);
        add_row(mk(0, -1, 2, 0), 1'b0, '0);
        add_row(mk(3, -5, -5, 1), 1'b0, '0);
        foreach (rows[i]) begin
            if (rows[i].typed) begin
                send_point(rows[i].pt);
                if (skyline_q.size() == 0 || skyline_q[$] !== rows[i].want) begin
                    $display("%0t: directed row %0d, expected %h, actual %h", $time, i,
                             rows[i].want, skyline_q.size() ? skyline_q[$] : '0);
                    fail_count++;
                end
            end else begin
                send_point(rows[i].pt);
            end
        end

        // Overflow: a full store, then extra points with the final one dropped too.
        for (int i = 0; i < CAP + 3; i++)
            send_point(mk(rcoord(2), rcoord(2), rcoord(2), i == CAP + 2));
        // Exactly full without a drop.
        for (int i = 0; i < CAP; i++)
            send_point(mk(rcoord(0), rcoord(0), rcoord(0), i == CAP - 1));

        // Random sets, mostly small; the last stretch runs without gaps.
        while (items_sent < 420) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 10);
            mode = $urandom_range(0, 2);
            if (items_sent > 360) quiet_end = 1'b1;
            for (int i = 0; i < n; i++)
                send_point(mk(rcoord(mode), rcoord(mode), rcoord(mode), i == n - 1));
        end

        start <= 1'b0;
        while (skyline_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
